// File: rtl/rcc_pkg.sv
// Package: command codes, word geometry and shared types for the range clear/count core.
`default_nettype none
package rcc_pkg;
    localparam int POS_W  = 11;
    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;
    localparam int POP_W  = 6;

    localparam logic [1:0] CMD_REFILL = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_COUNT  = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
    } t_range;
endpackage
`default_nettype wire

// File: rtl/rcc_word_unit.sv
// Shared word unit: range mask, masked popcount and cleared word for one bitmap word.
`default_nettype none
module rcc_word_unit (
    input  wire logic [rcc_pkg::WORD_W-1:0] i_word,
    input  wire logic                       i_first,
    input  wire logic                       i_last,
    input  wire rcc_pkg::t_range            i_range,
    output logic [rcc_pkg::POP_W-1:0]       o_pop,
    output logic [rcc_pkg::WORD_W-1:0]      o_cleared
);
    import rcc_pkg::*;

    logic [WORD_W-1:0] mask_lo;
    logic [WORD_W-1:0] mask_hi;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] hit;

    // bits below range_low and above range_high drop out at the end words
    assign mask_lo = i_first ? ({WORD_W{1'b1}} << i_range.lo[BIT_W-1:0]) : {WORD_W{1'b1}};
    assign mask_hi = i_last ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W-1) - i_range.hi[BIT_W-1:0]))
                            : {WORD_W{1'b1}};
    assign mask      = mask_lo & mask_hi;
    assign hit       = i_word & mask;
    assign o_cleared = i_word & ~mask;

    // count of set marks in the masked word
    always_comb begin
        o_pop = '0;
        for (int b = 0; b < WORD_W; b++) begin
            o_pop = o_pop + POP_W'(hit[b]);
        end
    end
endmodule
`default_nettype wire

// File: rtl/range_clear_range_count_tree_core.sv
// Top level: mark row bitmap, word sequencer and result register.
`default_nettype none
// Marks for positions 1..span are kept as a bitmap of 32-bit words in one memory,
// with one valid bit per word so a refill (command or span write) only clears the
// valid bits: an unwritten word reads as all set. Start is taken while busy is low.
// Refill, unused commands and rejected ranges finish without leaving idle; clear
// and count visit every word from range_low to range_high through one shared word
// unit, each by a registered memory read, then combine/write back; a new item is
// taken only once the last word is done. The result shows on o_done for one cycle,
// in the cycle busy drops after a clear or count; the receiver cannot stall.
module range_clear_range_count_tree_core #(
    parameter int MAX_POSITIONS = 1024
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [rcc_pkg::POS_W-1:0] i_cfg_wdata,
    input  wire logic                      i_start,
    output logic                           o_busy,
    input  wire logic [1:0]                i_cmd,
    input  wire logic [rcc_pkg::POS_W-1:0] i_range_low,
    input  wire logic [rcc_pkg::POS_W-1:0] i_range_high,
    output logic                           o_done,
    output logic [rcc_pkg::POS_W-1:0]      o_set_count,
    output logic                           o_range_error
);
    import rcc_pkg::*;

    localparam int NPOS  = (MAX_POSITIONS < 2047) ? MAX_POSITIONS : 2047;
    localparam int WORDS = (NPOS >> BIT_W) + 1;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [POS_W-1:0] SPAN_CAP = POS_W'(NPOS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_PROC = 2'd2;

    logic [WORD_W-1:0] mem [WORDS];
    logic [WORDS-1:0]  r_wvalid;
    logic [POS_W-1:0]  r_span;
    logic [1:0]        r_state;
    logic [1:0]        r_cmd;
    t_range            r_range;
    logic [AW-1:0]     r_word;
    logic [WORD_W-1:0] r_rdata;
    logic              r_rvalid;
    logic [POS_W-1:0]  r_acc;
    logic              r_done;
    logic [POS_W-1:0]  r_count;
    logic              r_err;

    logic [POS_W-1:0]  live_span;
    logic              bad_range;
    logic [AW-1:0]     word_lo;
    logic [AW-1:0]     word_hi;
    logic [WORD_W-1:0] cur_word;
    logic [POP_W-1:0]  pop;
    logic [WORD_W-1:0] cleared;
    logic [POS_W-1:0]  n_acc;

    assign live_span = (r_span > SPAN_CAP) ? SPAN_CAP : r_span;
    assign bad_range = (i_range_low == '0) || (i_range_low > i_range_high)
                       || (i_range_high > live_span);
    assign word_lo   = r_range.lo[AW+BIT_W-1:BIT_W];
    assign word_hi   = r_range.hi[AW+BIT_W-1:BIT_W];
    assign cur_word  = r_rvalid ? r_rdata : {WORD_W{1'b1}};
    assign n_acc     = r_acc + POS_W'(pop);

    rcc_word_unit u_unit (
        .i_word    (cur_word),
        .i_first   (r_word == word_lo),
        .i_last    (r_word == word_hi),
        .i_range   (r_range),
        .o_pop     (pop),
        .o_cleared (cleared)
    );

    // bitmap memory: registered read, write back of cleared words
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RD) begin
            r_rdata  <= mem[r_word];
        end
        if (r_state == ST_PROC && r_cmd == CMD_CLEAR) begin
            mem[r_word] <= cleared;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_span   <= POS_W'(1024);
            r_wvalid <= '0;
            r_done   <= 1'b0;
            r_rvalid <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                r_span   <= i_cfg_wdata;
                r_wvalid <= '0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_cmd   <= i_cmd;
                        r_range <= '{lo: i_range_low, hi: i_range_high};
                        r_acc   <= '0;
                        r_count <= '0;
                        r_err   <= 1'b0;
                        if (i_cmd == CMD_REFILL) begin
                            r_wvalid <= '0;
                            r_done   <= 1'b1;
                        end else if (i_cmd == CMD_CLEAR || i_cmd == CMD_COUNT) begin
                            if (bad_range) begin
                                r_err  <= 1'b1;
                                r_done <= 1'b1;
                            end else begin
                                r_word  <= i_range_low[AW+BIT_W-1:BIT_W];
                                r_state <= ST_RD;
                            end
                        end else begin
                            r_done <= 1'b1;
                        end
                    end
                end
                ST_RD: begin
                    r_rvalid <= r_wvalid[r_word];
                    r_state  <= ST_PROC;
                end
                ST_PROC: begin
                    r_acc <= n_acc;
                    if (r_cmd == CMD_CLEAR) begin
                        r_wvalid[r_word] <= 1'b1;
                    end
                    if (r_word == word_hi) begin
                        r_count <= (r_cmd == CMD_COUNT) ? n_acc : '0;
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_word  <= r_word + AW'(1);
                        r_state <= ST_RD;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_busy        = (r_state != ST_IDLE);
    assign o_done        = r_done;
    assign o_set_count   = r_count;
    assign o_range_error = r_err;

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("result shown while busy");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_range_error) |-> (o_set_count == '0))
        else $error("rejected range with nonzero count");
    a_refill_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_cmd == CMD_REFILL) |=> (o_done && !o_busy))
        else $error("refill did not finish in one cycle");
`endif
endmodule
`default_nettype wire
